// ===== sv/escape_sequence_decoder_top_macros.svh =====
// Assertion macros for the escape sequence decoder.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ESCAPE_SEQUENCE_DECODER_TOP_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define ESD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ESD_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== sv/esd_pkg.sv =====
// Shared types and character constants for the escape sequence decoder.
// No dependencies.
package esd_pkg;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LC_R   = 8'h72;
   localparam logic [7:0] CHAR_LC_N   = 8'h6E;
   localparam logic [7:0] CHAR_LC_T   = 8'h74;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_LC_X   = 8'h78;
   localparam logic [7:0] CHAR_UC_X   = 8'h58;
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_TAB    = 8'h09;
   localparam logic [7:0] BYTE_NUL    = 8'h00;

   // One queued command: one result, or two when dbl (backslash first).
   typedef struct packed {
      logic       dbl;
      logic [7:0] data;
      logic       valid;
      logic       err;
      logic       eot;
   } cmd_type;

endpackage

// ===== sv/esd_front.sv =====
// Front end: accepts characters, tracks escape state, queues result commands.
// Depends on esd_pkg.
module esd_front
   import esd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_char,
   input  logic       req_last_char,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       q_full,
   output logic       q_push,
   output cmd_type    q_cmd
);

   typedef enum logic [4:0] {
      MODE_NORMAL = 5'b00001,
      MODE_ESC    = 5'b00010,
      MODE_HEX_HI = 5'b00100,
      MODE_HEX_LO = 5'b01000,
      MODE_SKIP   = 5'b10000
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [3:0] nib_ff, nib_in;
   logic       accept;
   logic       emit;
   logic       hex_ok;
   logic [3:0] hex_val;
   cmd_type    cmd;

   // hex digit decode
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (req_in_char >= 8'h30 && req_in_char <= 8'h39) begin
         hex_val = req_in_char[3:0];
      end else if ((req_in_char >= 8'h41 && req_in_char <= 8'h46) ||
                   (req_in_char >= 8'h61 && req_in_char <= 8'h66)) begin
         hex_val = 4'(req_in_char[2:0] + 3'd1) + 4'd8;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      mode_in = mode_ff;
      nib_in  = nib_ff;
      emit    = 1'b0;
      cmd     = '{dbl: 1'b0, data: req_in_char, valid: 1'b1, err: 1'b0,
                  eot: req_last_char};
      unique case (mode_ff)
         MODE_ESC: begin
            mode_in = MODE_NORMAL;
            emit    = 1'b1;
            unique case (req_in_char)
               CHAR_LC_R:   cmd.data = BYTE_CR;
               CHAR_LC_N:   cmd.data = BYTE_LF;
               CHAR_LC_T:   cmd.data = BYTE_TAB;
               CHAR_ZERO:   cmd.data = BYTE_NUL;
               CHAR_BSLASH: cmd.data = CHAR_BSLASH;
               CHAR_LC_X, CHAR_UC_X: begin
                  if (req_last_char) begin
                     cmd = '{dbl: 1'b0, data: 8'd0, valid: 1'b0, err: 1'b1, eot: 1'b1};
                  end else begin
                     emit    = 1'b0;
                     mode_in = MODE_HEX_HI;
                  end
               end
               default: cmd.dbl = 1'b1;
            endcase
         end
         MODE_HEX_HI: begin
            if (!hex_ok || req_last_char) begin
               nib_in = 4'd0;
               if (req_last_char) begin
                  mode_in = MODE_NORMAL;
                  emit    = 1'b1;
                  cmd     = '{dbl: 1'b0, data: 8'd0, valid: 1'b0, err: 1'b1, eot: 1'b1};
               end else begin
                  mode_in = MODE_SKIP;
               end
            end else begin
               nib_in  = hex_val;
               mode_in = MODE_HEX_LO;
            end
         end
         MODE_HEX_LO: begin
            nib_in = 4'd0;
            if (!hex_ok) begin
               if (req_last_char) begin
                  mode_in = MODE_NORMAL;
                  emit    = 1'b1;
                  cmd     = '{dbl: 1'b0, data: 8'd0, valid: 1'b0, err: 1'b1, eot: 1'b1};
               end else begin
                  mode_in = MODE_SKIP;
               end
            end else begin
               mode_in  = MODE_NORMAL;
               emit     = 1'b1;
               cmd.data = {nib_ff, hex_val};
            end
         end
         MODE_SKIP: begin
            nib_in = 4'd0;
            if (req_last_char) begin
               mode_in = MODE_NORMAL;
               emit    = 1'b1;
               cmd     = '{dbl: 1'b0, data: 8'd0, valid: 1'b0, err: 1'b1, eot: 1'b1};
            end
         end
         default: begin
            mode_in = MODE_NORMAL;
            if (req_in_char == CHAR_BSLASH && !req_last_char) begin
               mode_in = MODE_ESC;
            end else begin
               emit = 1'b1;
            end
         end
      endcase
   end

   assign q_push = accept && emit;
   assign q_cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         nib_ff  <= 4'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         nib_ff  <= nib_in;
      end
   end

endmodule

// ===== sv/esd_fifo.sv =====
// Short command queue between front and back end.
// Depends on esd_pkg and the assertion macro header.
`include "escape_sequence_decoder_top_macros.svh"
module esd_fifo
   import esd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    full,
   output logic    empty
);

   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_cmd = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ESD_ASSERT_IMPL(a_no_overfill, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "queue overfull")
   `ESD_ASSERT_IMPL(a_push_space, clock, reset, push, !full, "push into full queue")
   `ESD_ASSERT_IMPL(a_pop_data, clock, reset, pop, !empty, "pop from empty queue")

endmodule

// ===== sv/esd_back.sv =====
// Back end: drains queued commands into the registered result stage.
// Depends on esd_pkg and the assertion macro header.
`include "escape_sequence_decoder_top_macros.svh"
module esd_back
   import esd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head_cmd,
   input  logic       q_empty,
   output logic       q_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_parse_error,
   output logic       rsp_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready
);

   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;     // backslash of a two-beat command sent
   logic [7:0] byte_ff, byte_in;
   logic       bval_ff, bval_in;
   logic       err_ff, err_in;
   logic       eot_ff, eot_in;
   logic       load;

   assign load = (!valid_ff || rsp_ready) && !q_empty;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      phase_in = phase_ff;
      byte_in  = byte_ff;
      bval_in  = bval_ff;
      err_in   = err_ff;
      eot_in   = eot_ff;
      q_pop    = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (head_cmd.dbl && !phase_ff) begin
            phase_in = 1'b1;
            byte_in  = CHAR_BSLASH;
            bval_in  = 1'b1;
            err_in   = 1'b0;
            eot_in   = 1'b0;
         end else begin
            phase_in = 1'b0;
            q_pop    = 1'b1;
            byte_in  = head_cmd.valid ? head_cmd.data : 8'd0;
            bval_in  = head_cmd.valid;
            err_in   = head_cmd.err;
            eot_in   = head_cmd.eot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bval_ff <= bval_in;
      err_ff  <= err_in;
      eot_ff  <= eot_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_byte_valid  = bval_ff;
   assign rsp_parse_error = err_ff;
   assign rsp_end_of_text = eot_ff;

   `ESD_ASSERT_IMPL(a_phase_out, clock, reset, phase_ff, valid_ff, "phase set with no result")
   `ESD_ASSERT_IMPL(a_phase_head, clock, reset, phase_ff, !q_empty, "two-beat command lost")
   `ESD_ASSERT_IMPL(a_err_form, clock, reset, valid_ff && err_ff, !bval_ff && eot_ff && byte_ff == 8'd0, "malformed error result")

endmodule

// ===== sv/escape_sequence_decoder_top.sv =====
// Escape sequence decoder top level: front end, command queue, back end.
// Throughput: one character per cycle while the queue is not full; an unknown escape
// yields two result beats, which the queue absorbs until it fills.
// Each command is written into the queue and then loaded into the result register.
// Reset (synchronous, active high) returns to normal mode and empties the queue.
// Depends on esd_pkg, esd_front, esd_fifo, esd_back.
module escape_sequence_decoder_top
   import esd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_char,
   input  logic       req_last_char,
   input  logic       req_valid,
   output logic       req_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_parse_error,
   output logic       rsp_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready
);

   // Front end classifies each beat and queues at most one command per beat.
   // Characters that open an escape queue nothing.
   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;

   esd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_in_char   (req_in_char),
      .req_last_char (req_last_char),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   // Queue lets the front keep taking characters while the result is stalled.
   esd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   // Back end splits two-beat commands and holds the result register.
   esd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_parse_error (rsp_parse_error),
      .rsp_end_of_text (rsp_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready)
   );

endmodule
